// ===== sv/i2cbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_pkg: shared types and constants of the I2C master bit engine
// Command codes, the tick record held in the front queue and the
// configuration bundle seen by the sequencer.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

   localparam int BYTE_BITS = 8;

   localparam logic [9:0]  HALF_PERIOD_RESET = 10'd5;
   localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd500;

   // Register map, indexed by address bit 2.
   localparam logic REG_HALF_PERIOD = 1'b0;
   localparam logic REG_ACK_TIMEOUT = 1'b1;

   typedef enum logic [2:0] {
      OP_START    = 3'd0,
      OP_STOP     = 3'd1,
      OP_WRITE    = 3'd2,
      OP_READ     = 3'd3,
      OP_ACK      = 3'd4,
      OP_NACK     = 3'd5,
      OP_WAIT_ACK = 3'd6
   } op_type;

   // The one opcode value that names no command.
   localparam logic [2:0] OP_UNUSED = 3'd7;

   // One tick of the bus timebase after classification.
   typedef struct packed {
      logic                   cmd_ok;
      op_type                 opcode;
      logic [BYTE_BITS-1:0]   write_data;
      logic                   sda_line;
   } tick_type;

   // Head of the front queue as seen by the sequencer.
   typedef struct packed {
      logic     valid;
      tick_type tick;
   } queue_type;

   typedef struct packed {
      logic [9:0]  half_period;
      logic [15:0] ack_timeout;
   } cfg_type;

endpackage

// ===== sv/i2cbe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_front: tick intake and classification
// Accepts request beats, marks which ones carry a usable command and holds
// them in a two-entry queue in front of the sequencer.
// ----------------------------------------------------------------------------
module i2cbe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd_valid,
   input  logic [2:0]            req_opcode,
   input  logic [7:0]            req_write_data,
   input  logic                  req_sda_line,
   output i2cbe_pkg::queue_type  head,
   input  logic                  pop
);
   import i2cbe_pkg::*;

   tick_type   entry_ff [2];
   tick_type   incoming;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   // Opcode seven is not a command: the tick still flows, only as an idle one.
   always_comb begin
      incoming.cmd_ok     = req_cmd_valid && (req_opcode != OP_UNUSED);
      incoming.opcode     = op_type'(req_opcode);
      incoming.write_data = req_write_data;
      incoming.sda_line   = req_sda_line;
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= incoming;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.tick  = entry_ff[rd_ptr_ff];

endmodule

// ===== sv/i2cbe_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_seq: I2C line sequencer
// Advances the bus sequence by one tick per step and keeps the driven lines
// and status in registers that also serve as the response register.
// ----------------------------------------------------------------------------
module i2cbe_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  i2cbe_pkg::cfg_type    cfg,
   input  i2cbe_pkg::queue_type  head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_scl_level,
   output logic                  rsp_sda_level,
   output logic                  rsp_sda_drive_enable,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic [7:0]            rsp_read_data,
   output logic                  rsp_ack_failed
);
   import i2cbe_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE, PH_ST_PRE, PH_ST_HIGH, PH_ST_LOW,
      PH_SP_A, PH_SP_B, PH_SP_C,
      PH_AK_A, PH_AK_B, PH_AK_C,
      PH_WR_SET, PH_WR_HIGH, PH_WR_TAIL,
      PH_RD_LOW, PH_RD_HIGH,
      PH_WA_RISE, PH_WA_POLL, PH_WA_TAIL
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [3:0]            bits_ff, bits_in;
   logic [BYTE_BITS-1:0]  shift_ff, shift_in;
   logic [11:0]           delay_ff, delay_in;
   logic [15:0]           polls_ff, polls_in;
   logic                  scl_ff, scl_in;
   logic                  sda_ff, sda_in;
   logic                  sda_en_ff, sda_en_in;
   logic                  fail_ff, fail_in;
   logic [BYTE_BITS-1:0]  read_ff, read_in;
   logic                  done_ff, done_in;
   logic                  rsp_valid_ff;
   logic                  step;
   logic [9:0]            half;
   logic [11:0]           h_x1, h_x2, h_x3, h_x4;
   logic [11:0]           delay_dec;
   logic [3:0]            bits_inc;
   logic [15:0]           polls_inc;
   tick_type              tick;

   assign tick = head.tick;
   assign step = head.valid && (!rsp_valid_ff || rsp_ready);
   assign pop  = step;

   // A half period of zero behaves as one.
   assign half = (cfg.half_period == 10'd0) ? 10'd1 : cfg.half_period;
   assign h_x1 = {2'b00, half};
   assign h_x2 = {1'b0, half, 1'b0};
   assign h_x4 = {half, 2'b00};
   assign h_x3 = h_x1 + h_x2;

   assign delay_dec = (delay_ff != 12'd0) ? delay_ff - 12'd1 : 12'd0;
   assign bits_inc  = bits_ff + 4'd1;
   assign polls_inc = (polls_ff != 16'hFFFF) ? polls_ff + 16'd1 : polls_ff;

   always_comb begin
      phase_in  = phase_ff;
      bits_in   = bits_ff;
      shift_in  = shift_ff;
      delay_in  = delay_ff;
      polls_in  = polls_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      sda_en_in = sda_en_ff;
      fail_in   = fail_ff;
      read_in   = read_ff;
      done_in   = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (tick.cmd_ok) begin
               unique case (tick.opcode)
                  OP_START: begin
                     phase_in = PH_ST_PRE;
                     delay_in = h_x4;
                  end
                  OP_STOP: begin
                     scl_in    = 1'b0;
                     sda_in    = 1'b0;
                     sda_en_in = 1'b1;
                     phase_in  = PH_SP_A;
                     delay_in  = h_x1;
                  end
                  OP_WRITE: begin
                     scl_in    = 1'b0;
                     bits_in   = 4'd0;
                     sda_in    = tick.write_data[BYTE_BITS-1];
                     sda_en_in = 1'b1;
                     shift_in  = {tick.write_data[BYTE_BITS-2:0], 1'b0};
                     phase_in  = PH_WR_SET;
                     delay_in  = h_x1;
                  end
                  OP_READ: begin
                     sda_en_in = 1'b0;
                     shift_in  = '0;
                     bits_in   = 4'd0;
                     phase_in  = PH_RD_LOW;
                     delay_in  = h_x1;
                  end
                  OP_ACK, OP_NACK: begin
                     scl_in    = 1'b0;
                     sda_in    = (tick.opcode == OP_NACK);
                     sda_en_in = 1'b1;
                     phase_in  = PH_AK_A;
                     delay_in  = h_x1;
                  end
                  OP_WAIT_ACK: begin
                     fail_in   = 1'b0;
                     polls_in  = 16'd0;
                     sda_en_in = 1'b0;
                     scl_in    = 1'b1;
                     phase_in  = PH_WA_RISE;
                     delay_in  = h_x1;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
         PH_WA_POLL: begin
            if (!tick.sda_line) begin
               scl_in   = 1'b0;
               phase_in = PH_WA_TAIL;
               delay_in = h_x3;
            end else begin
               polls_in = polls_inc;
               if (polls_inc >= cfg.ack_timeout) begin
                  fail_in   = 1'b1;
                  scl_in    = 1'b0;
                  sda_in    = 1'b0;
                  sda_en_in = 1'b1;
                  phase_in  = PH_SP_A;
                  delay_in  = h_x1;
               end
            end
         end
         default: begin
            if (delay_dec != 12'd0) begin
               delay_in = delay_dec;
            end else begin
               delay_in = 12'd0;
               unique case (phase_ff)
                  PH_ST_PRE: begin
                     sda_in    = 1'b1;
                     sda_en_in = 1'b1;
                     scl_in    = 1'b1;
                     phase_in  = PH_ST_HIGH;
                     delay_in  = h_x1;
                  end
                  PH_ST_HIGH: begin
                     sda_in   = 1'b0;
                     phase_in = PH_ST_LOW;
                     delay_in = h_x1;
                  end
                  PH_ST_LOW: begin
                     scl_in   = 1'b0;
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                  end
                  PH_SP_A: begin
                     scl_in   = 1'b1;
                     phase_in = PH_SP_B;
                     delay_in = h_x1;
                  end
                  PH_SP_B: begin
                     sda_in   = 1'b1;
                     phase_in = PH_SP_C;
                     delay_in = h_x4;
                  end
                  PH_AK_A: begin
                     scl_in   = 1'b1;
                     phase_in = PH_AK_B;
                     delay_in = h_x1;
                  end
                  PH_AK_B: begin
                     scl_in   = 1'b0;
                     phase_in = PH_AK_C;
                     delay_in = h_x2;
                  end
                  PH_WR_SET: begin
                     scl_in   = 1'b1;
                     phase_in = PH_WR_HIGH;
                     delay_in = h_x1;
                  end
                  PH_WR_HIGH: begin
                     scl_in  = 1'b0;
                     bits_in = bits_inc;
                     if (bits_inc < 4'(BYTE_BITS)) begin
                        sda_in    = shift_ff[BYTE_BITS-1];
                        sda_en_in = 1'b1;
                        shift_in  = {shift_ff[BYTE_BITS-2:0], 1'b0};
                        phase_in  = PH_WR_SET;
                     end else begin
                        phase_in  = PH_WR_TAIL;
                     end
                     delay_in = h_x1;
                  end
                  PH_RD_LOW: begin
                     scl_in   = 1'b1;
                     shift_in = {shift_ff[BYTE_BITS-2:0], tick.sda_line};
                     phase_in = PH_RD_HIGH;
                     delay_in = h_x1;
                  end
                  PH_RD_HIGH: begin
                     scl_in  = 1'b0;
                     bits_in = bits_inc;
                     if (bits_inc < 4'(BYTE_BITS)) begin
                        phase_in = PH_RD_LOW;
                        delay_in = h_x1;
                     end else begin
                        read_in  = shift_ff;
                        phase_in = PH_IDLE;
                        done_in  = 1'b1;
                     end
                  end
                  PH_WA_RISE: begin
                     phase_in = PH_WA_POLL;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bits_ff      <= 4'd0;
         shift_ff     <= '0;
         delay_ff     <= 12'd0;
         polls_ff     <= 16'd0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         sda_en_ff    <= 1'b0;
         fail_ff      <= 1'b0;
         read_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff  <= phase_in;
            bits_ff   <= bits_in;
            shift_ff  <= shift_in;
            delay_ff  <= delay_in;
            polls_ff  <= polls_in;
            scl_ff    <= scl_in;
            sda_ff    <= sda_in;
            sda_en_ff <= sda_en_in;
            fail_ff   <= fail_in;
            read_ff   <= read_in;
            done_ff   <= done_in;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_scl_level        = scl_ff;
   assign rsp_sda_level        = sda_ff;
   assign rsp_sda_drive_enable = sda_en_ff;
   assign rsp_busy_res         = (phase_ff != PH_IDLE);
   assign rsp_done_res         = done_ff;
   assign rsp_read_data        = read_ff;
   assign rsp_ack_failed       = fail_ff;

endmodule

// ===== sv/i2c_master_bit_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine: I2C master line sequencer
// Top level with the register port, the tick intake queue and the sequencer.
// ----------------------------------------------------------------------------
// Each request beat is one tick of the bus timebase and yields exactly one
// response beat with the driven SCL level, the SDA level and drive enable,
// busy, a one-tick done pulse, the last byte read and the ack-failed flag.
// The engine sustains one beat per clock while the response side is ready: the
// sequencer takes one tick per cycle from a two-entry queue, and its state
// registers double as the response register, so a request beat accepted into
// an empty queue is stepped from the queue into those state registers and is
// offered from there as a response beat. A command on a tick while a sequence
// runs is dropped, as is opcode seven. The half period (address 0x0, reset 5,
// zero acts as one) scales every delay; ack_timeout (address 0x4, reset 500)
// bounds how many high SDA samples wait-ack takes before it runs a stop and
// sets ack_failed. Write the registers only while no beat is in flight.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
   input  logic        clock,
   input  logic        reset,
   // Request channel: one tick per beat.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd_valid,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_write_data,
   input  logic        req_sda_line,
   // Response channel: one beat per tick.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic        rsp_sda_drive_enable,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_ack_failed,
   // Register port.
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import i2cbe_pkg::*;

   logic [9:0]  half_period_ff;
   logic [15:0] ack_timeout_ff;
   logic        csr_write;
   logic        reg_sel;
   cfg_type     cfg;
   queue_type   head;
   logic        pop;

   // Registers are a word apart; only address bit 2 selects between them,
   // the byte offset bits are ignored.
   assign pready    = 1'b1;
   assign reg_sel   = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
      end else if (csr_write) begin
         if (reg_sel == REG_HALF_PERIOD) begin
            half_period_ff <= pwdata[9:0];
         end else begin
            ack_timeout_ff <= pwdata[15:0];
         end
      end
   end

   assign prdata = (reg_sel == REG_ACK_TIMEOUT) ? {16'd0, ack_timeout_ff}
                                                : {22'd0, half_period_ff};

   assign cfg.half_period = half_period_ff;
   assign cfg.ack_timeout = ack_timeout_ff;

   // The front marks usable commands and buffers ticks so the request side
   // keeps flowing while a response beat waits.
   i2cbe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd_valid  (req_cmd_valid),
      .req_opcode     (req_opcode),
      .req_write_data (req_write_data),
      .req_sda_line   (req_sda_line),
      .head           (head),
      .pop            (pop)
   );

   // The sequencer steps once per tick whenever its response register is free.
   i2cbe_seq u_seq (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .head                 (head),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_scl_level        (rsp_scl_level),
      .rsp_sda_level        (rsp_sda_level),
      .rsp_sda_drive_enable (rsp_sda_drive_enable),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_done_res         (rsp_done_res),
      .rsp_read_data        (rsp_read_data),
      .rsp_ack_failed       (rsp_ack_failed)
   );

endmodule

// ===== sv/i2cbe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_checker: port-level checks for the I2C master bit engine
// Watches the response channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module i2cbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_scl_level,
   input logic        rsp_sda_level,
   input logic        rsp_sda_drive_enable,
   input logic        rsp_busy_res,
   input logic        rsp_done_res,
   input logic [7:0]  rsp_read_data,
   input logic        rsp_ack_failed
);
   logic last_busy_ff;

   // Busy flag of the most recently delivered beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_busy_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         last_busy_ff <= rsp_busy_res;
      end
   end

   // A completing beat reports the sequence as no longer running.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done beat still reports busy");

   // A command can only complete after a beat that showed it running.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_done_res |-> last_busy_ff)
      else $error("done beat without a preceding busy beat");

   // No response beat is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response beat holds its lines and its status other than busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scl_level)
         && $stable(rsp_sda_level) && $stable(rsp_sda_drive_enable)
         && $stable(rsp_done_res) && $stable(rsp_read_data)
         && $stable(rsp_ack_failed))
      else $error("stalled response beat changed");

endmodule

bind i2c_master_bit_engine i2cbe_checker u_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the I2C master bit engine
// Feeds tick beats into the request channel, predicts the driven lines of
// every tick with a cycle model of the sequencer, and checks each response
// beat in order. A short command table runs first, then random transactions
// under several half-period and ack-timeout settings.
// ----------------------------------------------------------------------------
module tb;
   import i2cbe_pkg::*;

   // Timing of the run. The engine registers each request beat in its queue and
   // then in its state registers before it offers the response beat.
   localparam int RESET_CYCLES    = 5;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int MAX_REPORTS     = 10;
   localparam int NUM_SETTINGS    = 5;

   // Register addresses.
   localparam logic [2:0] ADDR_HALF_PERIOD = 3'h0;
   localparam logic [2:0] ADDR_ACK_TIMEOUT = 3'h4;

   // How the bench drives the sampled SDA line while a directed row runs.
   localparam logic [1:0] SDA_LOW      = 2'd0;
   localparam logic [1:0] SDA_RELEASED = 2'd1;
   localparam logic [1:0] SDA_RANDOM   = 2'd2;

   // A wait-ack that never sees its slave pull SDA low.
   localparam logic [15:0] ACK_NEVER = 16'hFFFF;

   // Patterns of the response-side ready.
   localparam int READY_ALWAYS = 0;
   localparam int READY_COIN   = 1;
   localparam int READY_SPARSE = 2;
   localparam int READY_TOGGLE = 3;

   // Steps of the line sequencer, as the bench models them.
   typedef enum logic [4:0] {
      S_IDLE, S_START_PRE, S_START_HIGH, S_START_LOW,
      S_STOP_A, S_STOP_B, S_STOP_C,
      S_ACK_A, S_ACK_B, S_ACK_C,
      S_WR_SET, S_WR_HIGH, S_WR_TAIL,
      S_RD_LOW, S_RD_HIGH,
      S_WA_RISE, S_WA_POLL, S_WA_TAIL
   } seq_phase_type;

   // Everything a response beat carries.
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       oe;
      logic       busy;
      logic       done;
      logic [7:0] rd;
      logic       fail;
   } line_beat_type;

   // One row of the directed command table. Where typed is set, the first
   // beat of the row is checked against the value written in the row.
   typedef struct packed {
      logic          cv;
      logic [2:0]    op;
      logic [7:0]    wdata;
      logic [1:0]    sda_mode;
      logic          typed;
      line_beat_type exp;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd_valid = 1'b0;
   logic [2:0]  req_opcode = 3'd0;
   logic [7:0]  req_write_data = 8'd0;
   logic        req_sda_line = 1'b1;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_scl_level;
   logic        rsp_sda_level;
   logic        rsp_sda_drive_enable;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_read_data;
   logic        rsp_ack_failed;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   i2c_master_bit_engine dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd_valid        (req_cmd_valid),
      .req_opcode           (req_opcode),
      .req_write_data       (req_write_data),
      .req_sda_line         (req_sda_line),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_scl_level        (rsp_scl_level),
      .rsp_sda_level        (rsp_sda_level),
      .rsp_sda_drive_enable (rsp_sda_drive_enable),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_done_res         (rsp_done_res),
      .rsp_read_data        (rsp_read_data),
      .rsp_ack_failed       (rsp_ack_failed),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   // ------------------------------------------------------------------------
   // Sequencer model. Its state advances once per request beat, at the
   // moment the bench builds the beat, so the stimulus can look at where
   // the engine will be when that tick arrives.
   // ------------------------------------------------------------------------
   seq_phase_type seq_phase;
   logic [3:0]    seq_bits;
   logic [7:0]    seq_shift;
   logic [11:0]   seq_delay;
   logic [15:0]   seq_polls;
   logic          line_scl;
   logic          line_sda;
   logic          line_oe;
   logic          ack_fail;
   logic [7:0]    read_byte;
   logic          done_pulse;
   logic [9:0]    half_q;
   logic [15:0]   timeout_q;

   // Expected response beats, oldest first.
   line_beat_type pending_lines[$];

   // Bookkeeping for the summary and the verdict.
   int cmds_started  = 0;
   int timeouts_seen = 0;
   int ticks_sent    = 0;
   int beats_checked = 0;
   int bad_beats     = 0;
   int cycle_count   = 0;
   int burst_left    = 0;
   bit hold_off_request = 1'b0;

   function automatic line_beat_type pack_lines(input logic scl, input logic sda,
                                                input logic oe, input logic busy,
                                                input logic done, input logic [7:0] rd,
                                                input logic fail);
      line_beat_type b;
      b.scl  = scl;
      b.sda  = sda;
      b.oe   = oe;
      b.busy = busy;
      b.done = done;
      b.rd   = rd;
      b.fail = fail;
      return b;
   endfunction

   function automatic void reset_sequencer();
      half_q     = HALF_PERIOD_RESET;
      timeout_q  = ACK_TIMEOUT_RESET;
      seq_phase  = S_IDLE;
      seq_bits   = '0;
      seq_shift  = '0;
      seq_delay  = '0;
      seq_polls  = '0;
      line_scl   = 1'b1;
      line_sda   = 1'b1;
      line_oe    = 1'b0;
      ack_fail   = 1'b0;
      read_byte  = '0;
      done_pulse = 1'b0;
   endfunction

   // A half period of zero behaves as one.
   function automatic int unit_ticks();
      int h;
      h = int'(half_q);
      if (h == 0) h = 1;
      return h;
   endfunction

   function automatic void set_phase(input seq_phase_type p, input int d);
      seq_phase = p;
      seq_delay = 12'(d);
   endfunction

   function automatic void finish_cmd();
      seq_phase  = S_IDLE;
      seq_delay  = '0;
      done_pulse = 1'b1;
   endfunction

   function automatic void stop_begin();
      line_scl = 1'b0;
      line_sda = 1'b0;
      line_oe  = 1'b1;
      set_phase(S_STOP_A, unit_ticks());
   endfunction

   function automatic void shift_out_bit();
      line_sda  = seq_shift[BYTE_BITS-1];
      line_oe   = 1'b1;
      seq_shift = seq_shift << 1;
      set_phase(S_WR_SET, unit_ticks());
   endfunction

   // Line actions taken when a timed step runs out.
   function automatic void advance(input logic sda_in);
      int h;
      h = unit_ticks();
      case (seq_phase)
         S_START_PRE: begin
            line_sda = 1'b1;
            line_oe  = 1'b1;
            line_scl = 1'b1;
            set_phase(S_START_HIGH, h);
         end
         S_START_HIGH: begin
            line_sda = 1'b0;
            set_phase(S_START_LOW, h);
         end
         S_START_LOW: begin
            line_scl = 1'b0;
            finish_cmd();
         end
         S_STOP_A: begin
            line_scl = 1'b1;
            set_phase(S_STOP_B, h);
         end
         S_STOP_B: begin
            line_sda = 1'b1;
            set_phase(S_STOP_C, 4 * h);
         end
         S_ACK_A: begin
            line_scl = 1'b1;
            set_phase(S_ACK_B, h);
         end
         S_ACK_B: begin
            line_scl = 1'b0;
            set_phase(S_ACK_C, 2 * h);
         end
         S_WR_SET: begin
            line_scl = 1'b1;
            set_phase(S_WR_HIGH, h);
         end
         S_WR_HIGH: begin
            line_scl = 1'b0;
            seq_bits = seq_bits + 4'd1;
            if (seq_bits < BYTE_BITS) shift_out_bit();
            else set_phase(S_WR_TAIL, h);
         end
         S_RD_LOW: begin
            // Read data is taken on the tick SCL rises.
            line_scl  = 1'b1;
            seq_shift = {seq_shift[6:0], sda_in};
            set_phase(S_RD_HIGH, h);
         end
         S_RD_HIGH: begin
            line_scl = 1'b0;
            seq_bits = seq_bits + 4'd1;
            if (seq_bits < BYTE_BITS) begin
               set_phase(S_RD_LOW, h);
            end else begin
               read_byte = seq_shift;
               finish_cmd();
            end
         end
         S_WA_RISE: set_phase(S_WA_POLL, 0);
         default:   finish_cmd();
      endcase
   endfunction

   function automatic void accept_cmd(input logic [2:0] op, input logic [7:0] wd);
      int h;
      h = unit_ticks();
      case (op)
         OP_START: set_phase(S_START_PRE, 4 * h);
         OP_STOP:  stop_begin();
         OP_WRITE: begin
            line_scl  = 1'b0;
            seq_shift = wd;
            seq_bits  = '0;
            shift_out_bit();
         end
         OP_READ: begin
            line_oe   = 1'b0;
            seq_shift = '0;
            seq_bits  = '0;
            set_phase(S_RD_LOW, h);
         end
         OP_ACK, OP_NACK: begin
            line_scl = 1'b0;
            line_sda = (op == OP_NACK);
            line_oe  = 1'b1;
            set_phase(S_ACK_A, h);
         end
         default: begin
            // Wait-ack clears the failure flag as it starts.
            ack_fail  = 1'b0;
            seq_polls = '0;
            line_oe   = 1'b0;
            line_scl  = 1'b1;
            set_phase(S_WA_RISE, h);
         end
      endcase
   endfunction

   // Advance the model by one tick and return the lines it drives.
   function automatic line_beat_type predict_lines(input logic cv, input logic [2:0] op,
                                                   input logic [7:0] wd, input logic sda_in);
      done_pulse = 1'b0;
      if (seq_phase == S_IDLE) begin
         // Opcode seven is dropped and the engine stays idle.
         if (cv && op != OP_UNUSED) begin
            accept_cmd(op, wd);
            cmds_started++;
         end
      end else if (seq_phase == S_WA_POLL) begin
         if (!sda_in) begin
            line_scl = 1'b0;
            set_phase(S_WA_TAIL, 3 * unit_ticks());
         end else begin
            if (seq_polls != 16'hFFFF) seq_polls++;
            // A timeout of zero gives up on the first high sample.
            if (seq_polls >= timeout_q) begin
               ack_fail = 1'b1;
               timeouts_seen++;
               stop_begin();
            end
         end
      end else begin
         if (seq_delay > 0) seq_delay--;
         if (seq_delay == 0) advance(sda_in);
      end
      return pack_lines(line_scl, line_sda, line_oe, seq_phase != S_IDLE, done_pulse,
                        read_byte, ack_fail);
   endfunction

   function automatic dir_row_type dir_row(input logic cv, input logic [2:0] op,
                                           input logic [7:0] wdata, input logic [1:0] sda_mode,
                                           input logic typed, input line_beat_type exp);
      dir_row_type r;
      r.cv       = cv;
      r.op       = op;
      r.wdata    = wdata;
      r.sda_mode = sda_mode;
      r.typed    = typed;
      r.exp      = exp;
      return r;
   endfunction

   function automatic logic sda_for(input logic [1:0] mode);
      if (mode == SDA_RANDOM) return 1'($urandom_range(0, 1));
      return mode[0];
   endfunction

   // ------------------------------------------------------------------------
   // Request side. The sender works in bursts of random length; between
   // bursts it drops valid for a random gap, and about a third of the
   // bursts follow the previous one with no gap at all. Each beat's
   // expectation is queued before the beat is offered.
   // ------------------------------------------------------------------------
   task automatic issue_tick(input logic cv, input logic [2:0] op, input logic [7:0] wd,
                             input logic sda, input logic typed,
                             input line_beat_type typed_lines);
      line_beat_type predicted;
      int gap;
      predicted = predict_lines(cv, op, wd, sda);
      pending_lines.push_back(typed ? typed_lines : predicted);
      ticks_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_cmd_valid  <= cv;
      req_opcode     <= op;
      req_write_data <= wd;
      req_sda_line   <= sda;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // Let every expected beat come back, then give the engine a few more
   // cycles before anything touches its registers.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: a setup phase, then an access phase that completes at
   // the edge where pready is seen high. The bus then idles with psel low so
   // that a second write never changes psel twice in one step.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      if (addr == ADDR_HALF_PERIOD) half_q = data[9:0];
      else timeout_q = data[15:0];
   endtask

   // ------------------------------------------------------------------------
   // Clock and cycle limit.
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: cycle limit reached with %0d beats outstanding", pending_lines.size());
      $display("tb: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side. Ready follows patterns of random length of its own:
   // always high, a coin toss, mostly low, or toggling. Once, on request
   // from the stimulus, it holds low for a long stretch so the intake queue
   // fills and the request channel backs up.
   // ------------------------------------------------------------------------
   initial begin : ready_pattern
      int mode;
      int stretch;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         mode    = $urandom_range(READY_ALWAYS, READY_TOGGLE);
         stretch = $urandom_range(1, 60);
         repeat (stretch) begin
            case (mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:      rsp_ready <= ~rsp_ready;
            endcase
            @(posedge clock);
         end
      end
   end

   // Every response beat taken is compared with the oldest expectation.
   always @(posedge clock) begin : beat_monitor
      line_beat_type got;
      line_beat_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got = pack_lines(rsp_scl_level, rsp_sda_level, rsp_sda_drive_enable, rsp_busy_res,
                          rsp_done_res, rsp_read_data, rsp_ack_failed);
         beats_checked++;
         if (pending_lines.size() == 0) begin
            if (bad_beats < MAX_REPORTS)
               $display("tb: response beat %0d arrived with nothing expected", beats_checked);
            bad_beats++;
         end else begin
            want = pending_lines.pop_front();
            if (got !== want) begin
               if (bad_beats < MAX_REPORTS)
                  $display({"tb: beat %0d mismatch: expected scl=%b sda=%b oe=%b busy=%b ",
                            "done=%b rd=%h fail=%b, got scl=%b sda=%b oe=%b busy=%b done=%b ",
                            "rd=%h fail=%b"}, beats_checked,
                           want.scl, want.sda, want.oe, want.busy, want.done, want.rd,
                           want.fail, got.scl, got.sda, got.oe, got.busy, got.done, got.rd,
                           got.fail);
               bad_beats++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------
   dir_row_type directed_rows [0:16];

   // Random settings: the extremes of the timeout, zero values that the
   // engine treats as one, and a longer half period that gets one command.
   int cfg_half    [NUM_SETTINGS] = '{1, 0, 3, 2, 12};
   int cfg_timeout [NUM_SETTINGS] = '{1, 0, 7, 65535, 20};
   int cfg_budget  [NUM_SETTINGS] = '{100, 60, 90, 80, 1};

   initial begin : stimulus
      line_beat_type at_rest;
      line_beat_type start_taken;
      dir_row_type   r;
      logic [2:0]    op_plan[$];
      logic [15:0]   ack_delay;
      logic          cv;
      logic [2:0]    op;
      logic [7:0]    wd;
      logic          sda;
      int            i;
      int            s;
      int            n;
      int            phase_ticks;
      int            cmds_at_start;

      reset_sequencer();
      ack_delay = '0;

      // Lines straight out of reset, and the first beat of a start.
      at_rest     = pack_lines(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
      start_taken = pack_lines(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);

      // Every command once, data bytes at both extremes, reads of all
      // ones, all zeros and noise, an acked wait-ack, one that times out
      // against the reset timeout and a following one that clears the flag,
      // and stop and ack issued with no transaction open. While a row runs,
      // the filler ticks carry random commands that the engine must drop.
      directed_rows[0]  = dir_row(1'b0, OP_START,    8'h00, SDA_RELEASED, 1'b1, at_rest);
      directed_rows[1]  = dir_row(1'b1, OP_UNUSED,   8'hFF, SDA_RELEASED, 1'b1, at_rest);
      directed_rows[2]  = dir_row(1'b1, OP_START,    8'h00, SDA_RELEASED, 1'b1, start_taken);
      directed_rows[3]  = dir_row(1'b1, OP_WRITE,    8'hFF, SDA_RANDOM,   1'b0, '0);
      directed_rows[4]  = dir_row(1'b1, OP_WAIT_ACK, 8'h00, SDA_LOW,      1'b0, '0);
      directed_rows[5]  = dir_row(1'b1, OP_WRITE,    8'h00, SDA_RANDOM,   1'b0, '0);
      directed_rows[6]  = dir_row(1'b1, OP_WAIT_ACK, 8'h00, SDA_RELEASED, 1'b0, '0);
      directed_rows[7]  = dir_row(1'b1, OP_WAIT_ACK, 8'h00, SDA_LOW,      1'b0, '0);
      directed_rows[8]  = dir_row(1'b1, OP_READ,     8'h00, SDA_RELEASED, 1'b0, '0);
      directed_rows[9]  = dir_row(1'b1, OP_ACK,      8'h00, SDA_RANDOM,   1'b0, '0);
      directed_rows[10] = dir_row(1'b1, OP_READ,     8'hFF, SDA_LOW,      1'b0, '0);
      directed_rows[11] = dir_row(1'b1, OP_NACK,     8'h00, SDA_RANDOM,   1'b0, '0);
      directed_rows[12] = dir_row(1'b1, OP_READ,     8'h00, SDA_RANDOM,   1'b0, '0);
      directed_rows[13] = dir_row(1'b1, OP_STOP,     8'h00, SDA_RANDOM,   1'b0, '0);
      directed_rows[14] = dir_row(1'b1, OP_STOP,     8'h00, SDA_RANDOM,   1'b0, '0);
      directed_rows[15] = dir_row(1'b1, OP_ACK,      8'h00, SDA_RANDOM,   1'b0, '0);
      directed_rows[16] = dir_row(1'b1, OP_WRITE,    8'hA5, SDA_RANDOM,   1'b0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // The long receiver stall comes while the directed rows are offered.
      hold_off_request = 1'b1;

      for (i = 0; i < $size(directed_rows); i++) begin
         r = directed_rows[i];
         issue_tick(r.cv, r.op, r.wdata, sda_for(r.sda_mode), r.typed, r.exp);
         while (seq_phase != S_IDLE)
            issue_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                       8'($urandom_range(0, 255)), sda_for(r.sda_mode), 1'b0, '0);
      end
      wait_drained();

      // Random part. Most commands come from whole transactions (start,
      // address write and ack, a few data bytes each way, stop); the rest
      // are stray opcodes, opcode seven among them. A wait-ack usually gets
      // its ack after a few polls, and where the timeout is short enough it
      // sometimes never does, which runs the failure stop.
      for (s = 0; s < NUM_SETTINGS; s++) begin
         csr_write(ADDR_HALF_PERIOD, cfg_half[s]);
         csr_write(ADDR_ACK_TIMEOUT, cfg_timeout[s]);
         phase_ticks   = 0;
         cmds_at_start = cmds_started;
         while (phase_ticks < cfg_budget[s] || cmds_started == cmds_at_start ||
                seq_phase != S_IDLE) begin
            cv = 1'b0;
            op = 3'($urandom_range(0, 7));
            wd = 8'($urandom_range(0, 255));
            if (seq_phase == S_IDLE) begin
               if ($urandom_range(0, 99) < 75) begin
                  cv = 1'b1;
                  if ($urandom_range(0, 99) >= 12) begin
                     if (op_plan.size() == 0) begin
                        op_plan.push_back(OP_START);
                        op_plan.push_back(OP_WRITE);
                        op_plan.push_back(OP_WAIT_ACK);
                        n = $urandom_range(1, 3);
                        repeat (n) begin
                           if ($urandom_range(0, 1)) begin
                              op_plan.push_back(OP_WRITE);
                              op_plan.push_back(OP_WAIT_ACK);
                           end else begin
                              op_plan.push_back(OP_READ);
                              op_plan.push_back($urandom_range(0, 1) ? OP_ACK : OP_NACK);
                           end
                        end
                        op_plan.push_back(OP_STOP);
                     end
                     op = op_plan.pop_front();
                  end
                  if (op == OP_WAIT_ACK) begin
                     if (timeout_q <= 16'd600 && $urandom_range(0, 4) == 0) ack_delay = ACK_NEVER;
                     else ack_delay = 16'($urandom_range(0, 3));
                  end
               end
            end else begin
               // Commands offered mid-sequence must be ignored.
               cv = ($urandom_range(0, 3) == 0);
            end
            if (seq_phase == S_WA_POLL) begin
               sda = (ack_delay != 0);
               if (ack_delay != 0 && ack_delay != ACK_NEVER) ack_delay--;
            end else begin
               sda = 1'($urandom_range(0, 1));
            end
            issue_tick(cv, op, wd, sda, 1'b0, '0);
            phase_ticks++;
         end
         wait_drained();
      end

      if (pending_lines.size() != 0) bad_beats += pending_lines.size();

      $display("tb: %0d tick beats sent, %0d commands started, %0d ack timeouts",
               ticks_sent, cmds_started, timeouts_seen);
      $display("tb: %0d register settings after the reset values, %0d beats checked, %0d bad",
               NUM_SETTINGS, beats_checked, bad_beats);
      if (bad_beats == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
